### hw/rtl/bphd_pkg.sv
// ----------------------------------------------------------------------------
// bphd_pkg
// Shared types and constants for the button press/hold debouncer.
// ----------------------------------------------------------------------------
package bphd_pkg;

    localparam int NUM_BUTTONS_DEF = 2;

    localparam int THR_W   = 4;
    localparam int COUNT_W = 5;
    localparam int STATE_W = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] REG_PUSH_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 1'b1;

    localparam logic [THR_W-1:0] PUSH_THRESHOLD_RST = 4'd3;
    localparam logic [THR_W-1:0] HOLD_THRESHOLD_RST = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [THR_W-1:0] push;
        logic [THR_W-1:0] hold;
    } thr_t;

endpackage

### hw/rtl/bphd_cfg.sv
// ----------------------------------------------------------------------------
// bphd_cfg
// Threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module bphd_cfg
    import bphd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output thr_t                  thr
);

    thr_t thr_reg;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.push <= PUSH_THRESHOLD_RST;
            thr_reg.hold <= HOLD_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PUSH_THRESHOLD: thr_reg.push <= cfg_data;
                REG_HOLD_THRESHOLD: thr_reg.hold <= cfg_data;
                default:            thr_reg      <= thr_reg;
            endcase
        end
    end

endmodule

### hw/rtl/bphd_core.sv
// ----------------------------------------------------------------------------
// bphd_core
// Per-button state, previous state and tick counter, with the next-state
// logic for one tick sample.
// ----------------------------------------------------------------------------
module bphd_core
    import bphd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  logic [IDX_W-1:0]   idx,
    input  logic               pressed,
    input  thr_t               thr,
    output logic [STATE_W-1:0] result
);

    typedef enum logic [STATE_W-1:0] {
        ST_NONE     = 2'd0,
        ST_PUSHED   = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } btn_state_t;

    btn_state_t         cur_reg  [NUM_BUTTONS];
    btn_state_t         prev_reg [NUM_BUTTONS];
    logic [COUNT_W-1:0] cnt_reg  [NUM_BUTTONS];

    logic               in_range;
    logic [IDX_W-1:0]   rd_idx;
    btn_state_t         st;
    btn_state_t         st_next;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] cnt_bump;
    logic [COUNT_W-1:0] cnt_next;

    assign in_range = ({{(32-IDX_W){1'b0}}, idx} < NUM_BUTTONS);
    assign rd_idx   = in_range ? idx : '0;
    assign st       = cur_reg[rd_idx];
    assign cnt      = (cur_reg[rd_idx] != prev_reg[rd_idx]) ? '0 : cnt_reg[rd_idx];
    assign cnt_bump = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 1'b1;

    always_comb
    begin
        st_next  = st;
        cnt_next = cnt;
        case (st)
            ST_NONE:
            begin
                cnt_next = pressed ? cnt_bump : '0;
                if (cnt_next > {1'b0, thr.push})
                    st_next = ST_PUSHED;
            end
            ST_RELEASED:
            begin
                st_next = ST_NONE;
            end
            ST_PUSHED:
            begin
                if (!pressed)
                    st_next = ST_RELEASED;
                else
                begin
                    cnt_next = cnt_bump;
                    if (cnt_bump > {1'b0, thr.hold})
                        st_next = ST_HELD;
                end
            end
            ST_HELD:
            begin
                if (!pressed)
                    st_next = ST_NONE;
            end
            default:
            begin
                st_next = ST_NONE;
            end
        endcase
    end

    assign result = in_range ? st_next : ST_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cur_reg[i]  <= ST_NONE;
                prev_reg[i] <= ST_NONE;
                cnt_reg[i]  <= '0;
            end
        end
        else if (commit && in_range)
        begin
            cur_reg[rd_idx]  <= st_next;
            prev_reg[rd_idx] <= st;
            cnt_reg[rd_idx]  <= cnt_next;
        end
    end

endmodule

### hw/rtl/button_press_hold_debouncer.sv
// ----------------------------------------------------------------------------
// button_press_hold_debouncer
// Per-button debouncer reporting none, pushed, held and released states.
// ----------------------------------------------------------------------------
// Each accepted tick sample names a button and its pressed level and yields
// one result beat with that button's new state. A sample is captured in an
// input register; once the output register is free, the button's state is
// updated and the result is captured in the output register. One sample is
// taken every cycle while the output side keeps up. A button index at or
// beyond NUM_BUTTONS leaves all state untouched and reports none.
// Threshold registers may be written only while no sample is in flight; a
// new threshold applies from the next sample on.
module button_press_hold_debouncer
    import bphd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IDX_W-1:0]      button_index,
    input  logic                  pressed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATE_W-1:0]    button_state,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    thr_t               thr;
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_pressed_reg;
    logic               out_valid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic [STATE_W-1:0] result;
    logic               out_free;
    logic               s1_advance;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    assign out_valid    = out_valid_reg;
    assign button_state = out_state_reg;

    bphd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    bphd_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .IDX_W       (IDX_W)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .commit  (s1_advance),
        .idx     (s1_idx_reg),
        .pressed (s1_pressed_reg),
        .thr     (thr),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_idx_reg     <= button_index;
            s1_pressed_reg <= pressed;
        end
        if (s1_advance)
            out_state_reg <= result;
    end

endmodule

### hw/rtl/bphd_checker.sv
// ----------------------------------------------------------------------------
// bphd_checker
// Port-level checks for the button press/hold debouncer.
// ----------------------------------------------------------------------------
module bphd_checker
    import bphd_pkg::*;
#(
    parameter int IDX_W = 1
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [IDX_W-1:0]      button_index,
    input logic                  pressed,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [STATE_W-1:0]    button_state,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(button_state))
        else $error("result changed while stalled");

    // waiting input beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(button_index) && $stable(pressed))
        else $error("input beat changed while waiting");

    // empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // new result traces back to an accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching sample");

    // config channel always takes writes
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind button_press_hold_debouncer bphd_checker #(.IDX_W(IDX_W)) u_bphd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_index (button_index),
    .pressed      (pressed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_state (button_state),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
